@@ rtl/bca_pkg.sv @@
// Shared types, constants and rule helpers for the cellular automaton step block.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package bca_pkg;

  // Grid limits handed to the top-level parameters
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Field widths fixed by the interface
  localparam int POS_W     = 6;   // row / column of a result
  localparam int DIM_W     = 7;   // grid_width / grid_height registers
  localparam int LIM_W     = 4;   // survive / birth limits
  localparam int CNT_W     = 4;   // live neighbor count, 0..8
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam int GRID_WIDTH_RST    = 64;
  localparam int GRID_HEIGHT_RST   = 64;
  localparam int SURVIVE_LIMIT_RST = 3;
  localparam int BIRTH_LIMIT_RST   = 4;

  // Line buffer: one bank per row of the three-row window
  localparam int NUM_BANKS = 3;
  localparam int BANK_W    = 2;

  // Result queue
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = 3;
  localparam int FIFO_CNT_W    = 4;
  localparam int FIFO_HEADROOM = 4;   // two results in flight plus two from the new word

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_SURVIVE     = 2'd2,
    REG_BIRTH       = 2'd3
  } cfg_reg_t;

  // One column of the window as it leaves the line buffer stage
  typedef struct packed {
    logic             valid;
    logic             top;         // row r-2
    logic             mid;         // row r-1
    logic             bot;         // row r (incoming)
    logic             first_col;
    logic             second_col;
    logic             last_col;
    logic             has_row;     // r >= 1, results are due
    logic             frame_last;  // padding row
    logic [POS_W-1:0] row;         // r-1
    logic [POS_W-1:0] col;         // c
  } bca_col_t;

  // One result word
  typedef struct packed {
    logic             frame_end;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             next_alive;
  } bca_res_t;

  // Population count of the eight neighbors
  function automatic logic [CNT_W-1:0] count8(input logic [7:0] v);
    logic [CNT_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + CNT_W'(v[i]);
    end
    return s;
  endfunction

  // Survival / birth rule
  function automatic logic rule_next(input logic             self_alive,
                                     input logic [CNT_W-1:0] cnt,
                                     input logic [LIM_W-1:0] survive,
                                     input logic [LIM_W-1:0] birth);
    return self_alive ? (cnt >= survive) : (cnt > birth);
  endfunction

endpackage

`default_nettype wire

@@ rtl/bca_line_buf.sv @@
// Position counters, three-bank line buffer and the first pipeline register.
// Depends on bca_pkg.
`default_nettype none

module bca_line_buf #(
  parameter int MAX_WIDTH  = bca_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bca_pkg::MAX_HEIGHT_DEF,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            cell_bit,
  input  wire logic            restart,
  input  wire logic [CW-1:0]   w_last,
  input  wire logic [RW-1:0]   h_eff,
  output bca_pkg::bca_col_t    col_o
);
  import bca_pkg::*;

  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [BANK_W-1:0] bank_r, bank_nxt;

  logic [NUM_BANKS-1:0] mem [MAX_WIDTH];
  logic [NUM_BANKS-1:0] rd_r;

  logic              s1_valid_r;
  logic [BANK_W-1:0] s1_bank_r;
  logic              s1_bot_r;
  logic              s1_top_ok_r;
  logic              s1_first_r;
  logic              s1_second_r;
  logic              s1_last_r;
  logic              s1_has_row_r;
  logic              s1_frame_last_r;
  logic [POS_W-1:0]  s1_row_r;
  logic [POS_W-1:0]  s1_col_r;

  logic              pad_row;
  logic              wr_bit;
  logic [RW-1:0]     row_m1;
  logic              top_bit;
  logic              mid_bit;

  assign pad_row = (row_r == h_eff);
  assign wr_bit  = cell_bit & ~pad_row;
  assign row_m1  = row_r - RW'(1);

  // Raster position and bank rotation
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      bank_nxt = '0;
    end else if (accept) begin
      if (col_r == w_last) begin
        col_nxt = '0;
        if (pad_row) begin
          row_nxt  = '0;
          bank_nxt = '0;
        end else begin
          row_nxt  = row_r + RW'(1);
          bank_nxt = (bank_r == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_r + BANK_W'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      bank_r <= bank_nxt;
    end
  end

  // Line buffer: write the incoming row's bank, read the column from all banks
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[col_r][bank_r] <= wr_bit;
      rd_r               <= mem[col_r];
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bank_r       <= bank_r;
      s1_bot_r        <= wr_bit;
      s1_top_ok_r     <= (row_r > RW'(1));
      s1_first_r      <= (col_r == '0);
      s1_second_r     <= (col_r == CW'(1));
      s1_last_r       <= (col_r == w_last);
      s1_has_row_r    <= (row_r != '0);
      s1_frame_last_r <= pad_row;
      s1_row_r        <= POS_W'(row_m1);
      s1_col_r        <= POS_W'(col_r);
    end
  end

  // Bank b holds row r, b+2 row r-1, b+1 row r-2 (mod 3)
  always_comb begin
    case (s1_bank_r)
      2'd0: begin
        top_bit = rd_r[1];
        mid_bit = rd_r[2];
      end
      2'd1: begin
        top_bit = rd_r[2];
        mid_bit = rd_r[0];
      end
      2'd2: begin
        top_bit = rd_r[0];
        mid_bit = rd_r[1];
      end
      default: begin
        top_bit = 1'b0;
        mid_bit = 1'b0;
      end
    endcase
  end

  always_comb begin
    col_o.valid      = s1_valid_r;
    col_o.top        = top_bit & s1_top_ok_r;
    col_o.mid        = mid_bit & s1_has_row_r;
    col_o.bot        = s1_bot_r;
    col_o.first_col  = s1_first_r;
    col_o.second_col = s1_second_r;
    col_o.last_col   = s1_last_r;
    col_o.has_row    = s1_has_row_r;
    col_o.frame_last = s1_frame_last_r;
    col_o.row        = s1_row_r;
    col_o.col        = s1_col_r;
  end

endmodule

`default_nettype wire

@@ rtl/bca_rule.sv @@
// 3x3 window columns and the survival / birth rule; yields up to two results per word.
// Depends on bca_pkg.
`default_nettype none

module bca_rule (
  input  wire logic                        clk,
  input  wire bca_pkg::bca_col_t           col_i,
  input  wire logic [bca_pkg::LIM_W-1:0]   survive_limit,
  input  wire logic [bca_pkg::LIM_W-1:0]   born_thr,
  output logic                             push_a,
  output logic                             push_b,
  output bca_pkg::bca_res_t                res_a,
  output bca_pkg::bca_res_t                res_b
);
  import bca_pkg::*;

  // Columns c-1 and c-2, bit 2 top, bit 1 mid, bit 0 bottom
  logic [2:0] prev1_r;
  logic [2:0] prev2_r;
  logic [2:0] left_c;
  logic [2:0] mid_c;
  logic [2:0] cur_c;
  logic [7:0] nb_a;
  logic [7:0] nb_b;

  always_ff @(posedge clk) begin
    if (col_i.valid) begin
      prev1_r <= cur_c;
      prev2_r <= prev1_r;
    end
  end

  // Columns left of the grid edge read as dead
  assign cur_c  = {col_i.top, col_i.mid, col_i.bot};
  assign mid_c  = col_i.first_col ? 3'b000 : prev1_r;
  assign left_c = (col_i.first_col | col_i.second_col) ? 3'b000 : prev2_r;

  // Cell at column c-1 and, on the last column, the cell at column c
  assign nb_a = {left_c, mid_c[2], mid_c[0], cur_c};
  assign nb_b = {mid_c, cur_c[2], cur_c[0], 3'b000};

  assign push_a = col_i.valid & col_i.has_row & ~col_i.first_col;
  assign push_b = col_i.valid & col_i.has_row & col_i.last_col;

  always_comb begin
    res_a.next_alive = rule_next(mid_c[1], count8(nb_a), survive_limit, born_thr);
    res_a.row        = col_i.row;
    res_a.col        = col_i.col - POS_W'(1);
    res_a.frame_end  = 1'b0;

    res_b.next_alive = rule_next(cur_c[1], count8(nb_b), survive_limit, born_thr);
    res_b.row        = col_i.row;
    res_b.col        = col_i.col;
    res_b.frame_end  = col_i.frame_last;
  end

endmodule

`default_nettype wire

@@ rtl/bca_out_fifo.sv @@
// Result queue taking up to two words a cycle and presenting one to the output.
// Depends on bca_pkg.
`default_nettype none

module bca_out_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push_a,
  input  wire logic                           push_b,
  input  wire bca_pkg::bca_res_t              res_a,
  input  wire bca_pkg::bca_res_t              res_b,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bca_pkg::bca_res_t                   out_res,
  output logic                                room,
  output logic [bca_pkg::FIFO_CNT_W-1:0]      count
);
  import bca_pkg::*;

  bca_res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_r, wr_nxt;
  logic [FIFO_AW-1:0]     rd_r, rd_nxt;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FIFO_CNT_W-1:0]  n_push;
  logic                   pop;

  assign n_push    = FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b);
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_res   = mem[rd_r];
  assign room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - FIFO_HEADROOM));
  assign count     = cnt_r;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_nxt  = wr_r + FIFO_AW'(n_push);
    rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + n_push - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage; the column c-1 result goes ahead of the last-column result
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_r] <= res_a;
    end
    if (push_b) begin
      mem[push_a ? wr_r + FIFO_AW'(1) : wr_r] <= res_b;
    end
  end

endmodule

`default_nettype wire

@@ rtl/binary_cellular_automaton_step.sv @@
// One generation of a binary cellular automaton, one cell word accepted per clock while
// the result queue has room. Feed the grid in raster order followed by one padding row
// of grid_width words; the result for a cell leaves one row and one column behind its
// input, through the stage 1 register and the result queue. The end of every row
// yields two results for one input word, and the first column none; an 8-word result
// queue absorbs this, and in_tready is low during reset and drops only when more than
// four results wait in the queue. Writing grid_width or grid_height restarts the frame;
// write registers only while idle. The line buffer needs no clearing after reset: unread
// rows are masked by the row count.
// Depends on bca_pkg, bca_line_buf, bca_rule and bca_out_fifo.
`default_nettype none

module binary_cellular_automaton_step #(
  parameter int MAX_WIDTH  = bca_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bca_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [0] cell_alive
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [15:0]                            out_tdata,  // [0] next_alive, [6:1] out_row,
                                                             // [12:7] out_col
  output logic                                   out_tlast,  // frame_end
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bca_pkg::DIM_W-1:0]         cfg_data
);
  import bca_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RW      = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST   = (GRID_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RST;
  localparam int H_RST   = (GRID_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_HEIGHT_RST;

  logic [CW-1:0]    w_last_r, w_last_nxt;
  logic [RW-1:0]    h_eff_r, h_eff_nxt;
  logic [LIM_W-1:0] survive_r, survive_nxt;
  logic [LIM_W-1:0] birth_r, birth_nxt;
  logic             cfg_fire;
  logic             restart;
  logic             in_fire;

  bca_col_t               col_s1;
  logic                   push_a;
  logic                   push_b;
  bca_res_t               res_a;
  bca_res_t               res_b;
  bca_res_t               out_res;
  logic                   fifo_room;
  logic [FIFO_CNT_W-1:0]  fifo_count;

  // No word is taken while reset is held
  assign cfg_ready = rst_n;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_tready = fifo_room & rst_n;
  assign in_fire   = in_tvalid & in_tready;

  // Register writes; dimensions are clamped to 1..MAX on the way in
  always_comb begin
    w_last_nxt  = w_last_r;
    h_eff_nxt   = h_eff_r;
    survive_nxt = survive_r;
    birth_nxt   = birth_r;
    restart     = 1'b0;
    if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH: begin
          restart = 1'b1;
          if (cfg_data == '0) begin
            w_last_nxt = '0;
          end else if (cfg_data > DIM_W'(MAX_WIDTH)) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = CW'(cfg_data - DIM_W'(1));
          end
        end
        REG_GRID_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data == '0) begin
            h_eff_nxt = RW'(1);
          end else if (cfg_data > DIM_W'(MAX_HEIGHT)) begin
            h_eff_nxt = RW'(MAX_HEIGHT);
          end else begin
            h_eff_nxt = RW'(cfg_data);
          end
        end
        REG_SURVIVE: survive_nxt = cfg_data[LIM_W-1:0];
        REG_BIRTH:   birth_nxt   = cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= CW'(W_RST - 1);
      h_eff_r   <= RW'(H_RST);
      survive_r <= LIM_W'(SURVIVE_LIMIT_RST);
      birth_r   <= LIM_W'(BIRTH_LIMIT_RST);
    end else begin
      w_last_r  <= w_last_nxt;
      h_eff_r   <= h_eff_nxt;
      survive_r <= survive_nxt;
      birth_r   <= birth_nxt;
    end
  end

  bca_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_fire),
    .cell_bit (in_tdata[0]),
    .restart  (restart),
    .w_last   (w_last_r),
    .h_eff    (h_eff_r),
    .col_o    (col_s1)
  );

  bca_rule u_rule (
    .clk           (clk),
    .col_i         (col_s1),
    .survive_limit (survive_r),
    .born_thr      (birth_r),
    .push_a        (push_a),
    .push_b        (push_b),
    .res_a         (res_a),
    .res_b         (res_b)
  );

  bca_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .res_a     (res_a),
    .res_b     (res_b),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .room      (fifo_room),
    .count     (fifo_count)
  );

  assign out_tdata = {3'b000, out_res.col, out_res.row, out_res.next_alive};
  assign out_tlast = out_res.frame_end;

`ifndef SYNTHESIS
  // Queue fill never exceeds its depth
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // A word in stage 1 always finds room for both of its results
  a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    col_s1.valid |-> (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
    else $error("stage 1 word without queue room");

  // No second word enters while the queue is above the admission threshold
  a_admit: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_count > FIFO_CNT_W'(FIFO_DEPTH - FIFO_HEADROOM)) |=> !col_s1.valid ||
      $past(fifo_count) <= FIFO_CNT_W'(FIFO_DEPTH - FIFO_HEADROOM))
    else $error("word admitted over threshold");
`endif

endmodule

`default_nettype wire

@@ tb/sv/binary_cellular_automaton_step_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binary_cellular_automaton_step: streams whole and cut-short
// frames under random idling and stalls and checks every result word against a predictor.
// Depends on bca_pkg and the binary_cellular_automaton_step RTL.

module binary_cellular_automaton_step_tb;
  import bca_pkg::*;

  localparam int unsigned GRID_MAX_W    = MAX_WIDTH_DEF;
  localparam int unsigned GRID_MAX_H    = MAX_HEIGHT_DEF;
  localparam int          SETTLE_CYCLES = 12;    // pipeline plus result queue
  localparam int          STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int          RANDOM_CELLS  = 800;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // DUT ports, all driven to known values from time zero
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DIM_W-1:0]     cfg_data   = '0;

  binary_cellular_automaton_step u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Generation predictor state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [LIM_W-1:0] survive_reg;
  logic [LIM_W-1:0] birth_reg;
  logic [63:0]      row_above2;   // two rows above the incoming one
  logic [63:0]      row_above1;   // row just above
  logic [63:0]      row_incoming;
  int unsigned      col_pos;
  int unsigned      row_pos;

  bca_res_t expected_cells[$];
  logic     pending_cells[$];

  // Handshake bookkeeping
  logic in_fire     = 1'b0;
  int   idle_cycles = 0;
  int   fail_count  = 0;

  // Idling knobs, changed per phase
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int in_gap_left    = 0;
  int out_stall_left = 0;

  // Width / height as the block uses them: zero acts as one, clamped to the maximum
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw,
                                          input int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return 32'(raw);
  endfunction

  // Anything outside the row word counts as dead
  function automatic logic row_bit(input logic [63:0] bits, input int idx);
    if (idx < 0 || idx > 63) return 1'b0;
    return bits[idx];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit enabled);
    int unsigned sel;
    if (!enabled) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DIM_W-1:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return DIM_W'($urandom_range(2, 5));
    if (sel < 85) return DIM_W'($urandom_range(0, 15));
    return DIM_W'($urandom_range(16, 127));   // upper bits are dropped
  endfunction

  function automatic logic [DIM_W-1:0] pick_small_dim();
    if ($urandom_range(0, 9) == 0) return '0;
    return DIM_W'($urandom_range(1, 8));
  endfunction

  task automatic clear_frame();
    row_above2   = '0;
    row_above1   = '0;
    row_incoming = '0;
    col_pos      = 0;
    row_pos      = 0;
  endtask

  task automatic reset_predictor();
    width_reg   = DIM_W'(GRID_WIDTH_RST);
    height_reg  = DIM_W'(GRID_HEIGHT_RST);
    survive_reg = LIM_W'(SURVIVE_LIMIT_RST);
    birth_reg   = LIM_W'(BIRTH_LIMIT_RST);
    clear_frame();
  endtask

  task automatic apply_reg_write(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    case (idx)
      REG_GRID_WIDTH: begin
        width_reg = val;
        clear_frame();
      end
      REG_GRID_HEIGHT: begin
        height_reg = val;
        clear_frame();
      end
      REG_SURVIVE: survive_reg = val[LIM_W-1:0];
      REG_BIRTH:   birth_reg   = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // Next state of cell (y, x) from the three buffered rows
  task automatic push_next_state(input int unsigned y, input int x, input logic last);
    int       nbr;
    logic     self_on;
    bca_res_t res;
    nbr = 0;
    for (int d = -1; d <= 1; d++) begin
      nbr += int'(row_bit(row_above2, x + d));
      nbr += int'(row_bit(row_incoming, x + d));
      if (d != 0) nbr += int'(row_bit(row_above1, x + d));
    end
    self_on        = row_bit(row_above1, x);
    res.next_alive = self_on ? (nbr >= int'(survive_reg)) : (nbr > int'(birth_reg));
    res.row        = y[POS_W-1:0];
    res.col        = x[POS_W-1:0];
    res.frame_end  = last;
    expected_cells.push_back(res);
  endtask

  // One accepted word: store it, emit what is due one row and one column behind
  task automatic advance_grid(input logic alive);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    w = eff_dim(width_reg, GRID_MAX_W);
    h = eff_dim(height_reg, GRID_MAX_H);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r > h) r = h;
    if (r < h && alive) row_incoming[c] = 1'b1;
    if (r >= 1) begin
      if (c >= 1) push_next_state(r - 1, c - 1, 1'b0);
      if (c == w - 1) push_next_state(r - 1, c, r == h);
    end
    c++;
    if (c >= w) begin
      c = 0;
      // padding row done: back to the top of a fresh frame
      if (r >= h) begin
        clear_frame();
        return;
      end
      row_above2   = row_above1;
      row_above1   = row_incoming;
      row_incoming = '0;
      r++;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_result();
    bca_res_t want;
    if (expected_cells.size() == 0) begin
      note_failure($sformatf("result word with none pending: data %h last %b",
                             out_tdata, out_tlast));
      return;
    end
    want = expected_cells.pop_front();
    if (out_tdata[0] !== want.next_alive || out_tdata[6:1] !== want.row ||
        out_tdata[12:7] !== want.col || out_tlast !== want.frame_end)
      note_failure($sformatf(
        "mismatch: exp alive %b row %0d col %0d end %b, got alive %b row %0d col %0d end %b",
        want.next_alive, want.row, want.col, want.frame_end,
        out_tdata[0], out_tdata[6:1], out_tdata[12:7], out_tlast));
  endtask

  // Monitor: sample handshakes at the rising edge, predict and check
  always @(posedge clk) begin
    in_fire = in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_reg_t'(cfg_index), cfg_data);
      if (in_fire) advance_grid(in_tdata[0]);
      if (out_tvalid && out_tready) check_result();
      if (in_fire || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Cell word driver, fed from pending_cells
  always @(negedge clk) begin
    logic nxt_valid;
    logic nxt_bit;
    nxt_valid = in_tvalid;
    nxt_bit   = in_tdata[0];
    if (rst_n && (!in_tvalid || in_fire)) begin
      nxt_valid = 1'b0;
      if (in_gap_left != 0) begin
        in_gap_left--;
      end else if (pending_cells.size() != 0) begin
        nxt_bit     = pending_cells.pop_front();
        nxt_valid   = 1'b1;
        in_gap_left = pick_gap(gaps_on);
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= {7'b0, nxt_bit};
  end

  // Result side back-pressure
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (out_stall_left != 0) begin
        out_stall_left--;
      end else begin
        nxt_ready = 1'b1;
        if (stalls_on && $urandom_range(0, 99) < 25) out_stall_left = pick_gap(1'b1);
      end
    end
    out_tready <= nxt_ready;
  end

  // Watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("binary_cellular_automaton_step regression: fail");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_cells(input int unsigned n, input int unsigned density);
    for (int unsigned i = 0; i < n; i++)
      pending_cells.push_back($urandom_range(0, 99) < density);
  endtask

  // Sender runs dry and every expected word comes back, then the block settles
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_cells.size() != 0 || in_tvalid || expected_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    int unsigned      frame_words;
    int unsigned      grid_cells;
    int unsigned      density;
    int unsigned      style;
    int unsigned      sel;
    int unsigned      cut;
    int unsigned      random_cells;
    bit               must_restart;

    reset_predictor();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 3x2 grid, everything alive, loosest limits
    write_reg(REG_GRID_WIDTH, 7'd3);
    write_reg(REG_GRID_HEIGHT, 7'd2);
    write_reg(REG_SURVIVE, 7'd0);
    write_reg(REG_BIRTH, 7'd0);
    push_cells(9, 100);
    wait_quiet();

    // Survival above eight and birth at eight: nothing lives
    write_reg(REG_SURVIVE, 7'd9);
    write_reg(REG_BIRTH, 7'd8);
    for (int i = 0; i < 9; i++) pending_cells.push_back(i[0]);
    wait_quiet();

    // Zero dimensions act as a single cell; limits with high bits set
    write_reg(REG_GRID_WIDTH, 7'd0);
    write_reg(REG_GRID_HEIGHT, 7'd0);
    write_reg(REG_SURVIVE, 7'h7F);
    write_reg(REG_BIRTH, 7'h0F);
    push_cells(1, 100);
    push_cells(1, 0);
    wait_quiet();
    write_reg(REG_SURVIVE, 7'd0);
    push_cells(2, 100);
    wait_quiet();

    // Frame cut short; the next dimension write restarts it
    write_reg(REG_GRID_WIDTH, 7'd3);
    write_reg(REG_GRID_HEIGHT, 7'd2);
    push_cells(4, 50);
    wait_quiet();
    must_restart = 1'b1;
    w_raw        = 7'd3;
    h_raw        = 7'd2;

    // Random frames
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        w_raw = DIM_W'($urandom_range(64, 127));
        h_raw = DIM_W'($urandom_range(0, 2));
      end else if (sel < 10) begin
        w_raw = DIM_W'($urandom_range(0, 3));
        h_raw = DIM_W'($urandom_range(64, 127));
      end else if (sel < 25) begin
        w_raw = DIM_W'($urandom_range(9, 63));
        h_raw = DIM_W'($urandom_range(0, 3));
      end else if (sel < 85 || must_restart) begin
        w_raw = pick_small_dim();
        h_raw = pick_small_dim();
      end
      if (must_restart || sel < 85 || $urandom_range(0, 1) == 1)
        write_reg(REG_GRID_WIDTH, w_raw);
      if (sel < 85 || $urandom_range(0, 1) == 1)
        write_reg(REG_GRID_HEIGHT, h_raw);
      must_restart = 1'b0;
      if ($urandom_range(0, 1) == 1) write_reg(REG_SURVIVE, pick_limit());
      if ($urandom_range(0, 1) == 1) write_reg(REG_BIRTH, pick_limit());

      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      sel       = $urandom_range(0, 9);
      density   = (sel == 0) ? 0 : (sel == 1) ? 100 : $urandom_range(20, 80);

      grid_cells  = eff_dim(w_raw, GRID_MAX_W) * eff_dim(h_raw, GRID_MAX_H);
      frame_words = grid_cells + eff_dim(w_raw, GRID_MAX_W);
      style       = $urandom_range(0, 9);
      if (style == 0 && frame_words > 1) begin
        // broken frame: stop partway, force a restart next time round
        cut = $urandom_range(1, frame_words - 1);
        push_cells(cut, density);
        must_restart = 1'b1;
      end else if (style == 1) begin
        // sender holds mid-frame until the block has drained, maybe retunes limits
        cut = frame_words / 2;
        push_cells(cut, density);
        wait_quiet();
        if ($urandom_range(0, 1) == 1) write_reg(REG_SURVIVE, pick_limit());
        if ($urandom_range(0, 1) == 1) write_reg(REG_BIRTH, pick_limit());
        push_cells(frame_words - cut, density);
      end else begin
        push_cells(frame_words, density);
        // back-to-back frame with no register write in between
        if (style == 2) begin
          push_cells(frame_words, density);
          random_cells += frame_words;
        end
      end
      random_cells += frame_words;
      wait_quiet();
    end

    // Wrap-up: anything late or extra shows up here
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_cells.size() == 0)
      $display("binary_cellular_automaton_step regression: pass");
    else
      $display("binary_cellular_automaton_step regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bca_pkg.sv
rtl/bca_line_buf.sv
rtl/bca_rule.sv
rtl/bca_out_fifo.sv
rtl/binary_cellular_automaton_step.sv
tb/sv/binary_cellular_automaton_step_tb.sv
